[design/trrc_pkg.sv]
// Shared types and constants for the tandem repeat run counter.
`timescale 1ns / 1ps

package trrc_pkg;

    // Fixed geometry of the pattern and of the base window
    localparam int PAT_CAP    = 16;
    localparam int BASE_W     = 2;
    localparam int LEN_W      = 5;
    localparam int PHASE_W    = 4;
    localparam int WINDOW_W   = PAT_CAP * BASE_W;
    localparam int RESULT_W   = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd4;

    // Configuration register index, taken from paddr[2]
    typedef enum logic {
        REG_LENGTH  = 1'b0,
        REG_PATTERN = 1'b1
    } t_reg_idx;

    // Per-base control passed to the run counter bank
    typedef struct packed {
        logic               upd;    // full window present: update the phase counter
        logic               hit;    // window equals the pattern
        logic               clr;    // final base: clear after this update
        logic [PHASE_W-1:0] phase;  // counter to update
    } t_run_ctl;

endpackage

[design/trrc_match.sv]
// Window-to-pattern comparator for the active pattern length.
`timescale 1ns / 1ps

module trrc_match
    import trrc_pkg::*;
(
    input  logic [WINDOW_W-1:0] i_window,
    input  logic [WINDOW_W-1:0] i_pattern,
    input  logic [LEN_W-1:0]    i_len,
    output logic                o_match
);

    // Pattern base k lines up with window base len-1-k (newest base sits lowest)
    always_comb begin
        logic [PHASE_W-1:0] pos;
        logic [BASE_W-1:0]  wb;
        o_match = 1'b1;
        for (int k = 0; k < PAT_CAP; k++) begin
            pos = PHASE_W'(i_len - LEN_W'(1) - LEN_W'(k));
            wb  = i_window[{pos, 1'b0} +: BASE_W];
            if ((LEN_W'(k) < i_len) && (wb != i_pattern[k*BASE_W +: BASE_W])) begin
                o_match = 1'b0;
            end
        end
    end

endmodule

[design/trrc_runs.sv]
// Per-phase run counters and best-run register.
`timescale 1ns / 1ps

module trrc_runs
    import trrc_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int RUN_WIDTH   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_run_ctl             i_ctl,
    output logic [RUN_WIDTH-1:0] o_best_next
);

    localparam int NPH = (MAX_PATTERN < PAT_CAP) ? MAX_PATTERN : PAT_CAP;
    localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;

    logic [RUN_WIDTH-1:0] r_run [NPH];
    logic [RUN_WIDTH-1:0] r_best;
    logic [RUN_WIDTH-1:0] cur_run;
    logic [RUN_WIDTH-1:0] new_run;

    // Select the counter of the current phase
    always_comb begin
        cur_run = '0;
        for (int i = 0; i < NPH; i++) begin
            if (i_ctl.phase == PHASE_W'(i)) begin
                cur_run = r_run[i];
            end
        end
    end

    assign new_run = !i_ctl.hit ? '0 :
                     (cur_run == RUN_MAX) ? cur_run : cur_run + RUN_WIDTH'(1);

    assign o_best_next = (i_ctl.upd && (new_run > r_best)) ? new_run : r_best;

    for (genvar g = 0; g < NPH; g++) begin : g_phase
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_run[g] <= '0;
            end else if (i_en) begin
                if (i_ctl.clr) begin
                    r_run[g] <= '0;
                end else if (i_ctl.upd && (i_ctl.phase == PHASE_W'(g))) begin
                    r_run[g] <= new_run;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (i_en) begin
            r_best <= i_ctl.clr ? '0 : o_best_next;
        end
    end

endmodule

[design/tandem_repeat_run_counter.sv]
// Top level of the tandem repeat run counter: handshakes, config and base tracking.
`timescale 1ns / 1ps

//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+------------------------------
//  base     | in        | i_base_valid / o_base_ready   | i_base[1:0], i_last_base
//  run      | out       | o_run_valid / i_run_ready     | o_run_count[15:0]
//  config   | in        | psel, penable, pwrite, pready | paddr[2:0], pwdata, prdata
//
//  One base is taken per clock while the input register does not stall. An
//  accepted base is held in the input register; from there the window compare
//  and the phase counter update are done together, and the result of a final
//  base is registered in the output register, which drives o_run_valid. The input
//  register stalls only when a final base waits for the output register, which
//  still holds an untaken result.
//  i_rst_n is synchronous: it clears all tracking state and puts the
//  registers at length 4, pattern 0. The clear after a final base keeps them.

module tandem_repeat_run_counter
    import trrc_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int RUN_WIDTH   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // base channel
    input  logic                  i_base_valid,
    output logic                  o_base_ready,
    input  logic [BASE_W-1:0]     i_base,
    input  logic                  i_last_base,
    // result channel
    output logic                  o_run_valid,
    input  logic                  i_run_ready,
    output logic [RESULT_W-1:0]   o_run_count,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LEN_CAP = (MAX_PATTERN < PAT_CAP) ? MAX_PATTERN : PAT_CAP;

    // Configuration registers
    logic [LEN_W-1:0]    r_len_cfg;
    logic [WINDOW_W-1:0] r_pattern;

    // Input register
    logic                r_in_valid;
    logic [BASE_W-1:0]   r_in_base;
    logic                r_in_last;

    // Sequence tracking
    logic [WINDOW_W-1:0] r_window;
    logic [WINDOW_W-1:0] n_window;
    logic [LEN_W-1:0]    r_seen;
    logic [LEN_W-1:0]    n_seen;
    logic [PHASE_W-1:0]  r_phase;
    logic [PHASE_W-1:0]  n_phase;

    // Output register
    logic                r_out_valid;
    logic [RESULT_W-1:0] r_out_run;

    logic                  out_free;
    logic                  proc;
    logic [LEN_W-1:0]      len;
    logic [PHASE_W-1:0]    cur_phase;
    logic                  hit;
    t_run_ctl              run_ctl;
    logic [RUN_WIDTH-1:0]  best_next;
    logic [RUN_WIDTH+RESULT_W-1:0] best_ext;
    logic [RESULT_W-1:0]   best_sat;
    logic                  cfg_wr;

    // ---------------------------------------------------------------------
    // Configuration port: always ready, written in the access phase
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= LEN_RESET;
            r_pattern <= '0;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[2]))
                REG_LENGTH:  r_len_cfg <= pwdata[LEN_W-1:0];
                REG_PATTERN: r_pattern <= pwdata[WINDOW_W-1:0];
                default:     r_len_cfg <= r_len_cfg;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_LENGTH:  prdata = APB_DATA_W'(r_len_cfg);
            REG_PATTERN: prdata = APB_DATA_W'(r_pattern);
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Handshake: process the held base unless it is final and the output is full
    // ---------------------------------------------------------------------
    assign out_free     = !r_out_valid || i_run_ready;
    assign proc         = r_in_valid && (!r_in_last || out_free);
    assign o_base_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_base_ready) begin
            r_in_valid <= i_base_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_base_ready && i_base_valid) begin
            r_in_base <= i_base;
            r_in_last <= i_last_base;
        end
    end

    // ---------------------------------------------------------------------
    // Per-base work
    // ---------------------------------------------------------------------
    // Clamp the length: zero acts as one, the top is capped
    always_comb begin
        if (r_len_cfg == '0) begin
            len = LEN_W'(1);
        end else if (r_len_cfg > LEN_W'(LEN_CAP)) begin
            len = LEN_W'(LEN_CAP);
        end else begin
            len = r_len_cfg;
        end
    end

    // Wrap a phase left beyond a shortened length
    assign cur_phase = (LEN_W'(r_phase) >= len) ? '0 : r_phase;
    assign n_phase   = (LEN_W'(cur_phase) + LEN_W'(1) >= len) ? '0 : cur_phase + PHASE_W'(1);

    // Shift the new base in at the low end; count bases up to the cap
    assign n_window = {r_window[WINDOW_W-BASE_W-1:0], r_in_base};
    assign n_seen   = (r_seen < LEN_W'(PAT_CAP)) ? r_seen + LEN_W'(1) : r_seen;

    trrc_match u_match (
        .i_window  (n_window),
        .i_pattern (r_pattern),
        .i_len     (len),
        .o_match   (hit)
    );

    assign run_ctl.upd   = (n_seen >= len);
    assign run_ctl.hit   = hit;
    assign run_ctl.clr   = r_in_last;
    assign run_ctl.phase = cur_phase;

    trrc_runs #(
        .MAX_PATTERN (MAX_PATTERN),
        .RUN_WIDTH   (RUN_WIDTH)
    ) u_runs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (proc),
        .i_ctl       (run_ctl),
        .o_best_next (best_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_seen   <= '0;
            r_phase  <= '0;
        end else if (proc) begin
            if (r_in_last) begin
                r_window <= '0;
                r_seen   <= '0;
                r_phase  <= '0;
            end else begin
                r_window <= n_window;
                r_seen   <= n_seen;
                r_phase  <= n_phase;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result: saturate the best run to the output width
    // ---------------------------------------------------------------------
    assign best_ext = {{RESULT_W{1'b0}}, best_next};
    assign best_sat = (|best_ext[RUN_WIDTH+RESULT_W-1:RESULT_W]) ? '1
                                                                 : best_ext[RESULT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_run_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_out_run <= best_sat;
        end
    end

    assign o_run_valid = r_out_valid;
    assign o_run_count = r_out_run;

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase < PHASE_W'(LEN_CAP)) || (LEN_CAP == PAT_CAP))
        else $error("phase index beyond the counter bank");

    a_seen_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= LEN_W'(PAT_CAP))
        else $error("base count above its cap");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_last) |=> (r_seen == '0 && r_phase == '0 && r_window == '0))
        else $error("tracking state not cleared after final base");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(proc && r_in_last))
        else $error("result raised without a final base");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_run_ready) |-> !(proc && r_in_last))
        else $error("final base processed over an untaken result");
`endif

endmodule
